// ===== hw/rtl/tea_pkg.sv =====
// Package with the shared constants, types and round-sum function of the TEA block cipher.
package tea_pkg;

   localparam int unsigned ROUND_COUNT = 32;
   localparam int unsigned STAGE_COUNT = 2 * ROUND_COUNT;
   localparam int unsigned WORD_WIDTH  = 32;
   localparam int unsigned INDEX_WIDTH = 3;

   localparam logic [WORD_WIDTH-1:0] TEA_DELTA = 32'h9E37_79B9;

   localparam logic [INDEX_WIDTH-1:0] KEY_ZERO_INDEX  = 3'd0;
   localparam logic [INDEX_WIDTH-1:0] KEY_ONE_INDEX   = 3'd1;
   localparam logic [INDEX_WIDTH-1:0] KEY_TWO_INDEX   = 3'd2;
   localparam logic [INDEX_WIDTH-1:0] KEY_THREE_INDEX = 3'd3;

   localparam logic KIND_ENCRYPT = 1'b0;
   localparam logic KIND_DECRYPT = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [WORD_WIDTH-1:0] first;
      logic [WORD_WIDTH-1:0] second;
   } stage_type;

   // Running sum used by a given half-round stage. Encryption round r uses
   // delta * (r + 1); decryption round r uses delta * (ROUND_COUNT - r).
   function automatic logic [WORD_WIDTH-1:0] stage_sum(input int unsigned stage,
                                                      input logic        decrypt);
      int unsigned           round_number;
      logic [WORD_WIDTH-1:0] multiple;
      round_number = stage >> 1;
      if (decrypt) begin
         multiple = WORD_WIDTH'(ROUND_COUNT - round_number);
      end else begin
         multiple = WORD_WIDTH'(round_number + 1);
      end
      return WORD_WIDTH'(TEA_DELTA * multiple);
   endfunction

endpackage

// ===== hw/rtl/tea_block_cipher.sv =====
// Top level of the TEA block cipher: key registers and the unrolled half-round pipeline.
//
// Usage: the 128-bit key is loaded through the csr_ port, one 32-bit word per write,
// at indexes 0 to 3; writes to higher indexes are ignored. Keys should only change
// while no item is in flight.
// An item (req_kind, req_first_half, req_second_half) is accepted at a rising edge
// where start is high and busy is low. req_kind 0 encrypts, 1 decrypts.
// Every item leaves as one result on rsp_result_first and rsp_result_second, marked
// by rsp_valid for exactly one cycle, in the order the items were accepted.
// Throughput: one item per cycle, sustained. The item passes one registered pipeline
// stage per half-round of the 32 rounds; each stage holds one mix function and one
// add or subtract.
// Reset clears all pipeline valid bits, so items in flight are dropped, and sets the
// key to zero; busy is high only during reset.
// The receiver cannot hold results off, so the pipeline never stalls.
module tea_block_cipher (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [tea_pkg::WORD_WIDTH-1:0]      req_first_half,
   input  logic [tea_pkg::WORD_WIDTH-1:0]      req_second_half,
   output logic                                rsp_valid,
   output logic [tea_pkg::WORD_WIDTH-1:0]      rsp_result_first,
   output logic [tea_pkg::WORD_WIDTH-1:0]      rsp_result_second,
   input  logic                                csr_write_enable,
   input  logic [tea_pkg::INDEX_WIDTH-1:0]     csr_index,
   input  logic [tea_pkg::WORD_WIDTH-1:0]      csr_write_data
);

   localparam int unsigned LAST = tea_pkg::STAGE_COUNT - 1;

   logic [tea_pkg::WORD_WIDTH-1:0] key_zero_ff, key_zero_in;
   logic [tea_pkg::WORD_WIDTH-1:0] key_one_ff, key_one_in;
   logic [tea_pkg::WORD_WIDTH-1:0] key_two_ff, key_two_in;
   logic [tea_pkg::WORD_WIDTH-1:0] key_three_ff, key_three_in;

   logic [tea_pkg::STAGE_COUNT-1:0] valid_ff, valid_in;
   tea_pkg::stage_type              pipe_ff [tea_pkg::STAGE_COUNT];
   tea_pkg::stage_type              pipe_in [tea_pkg::STAGE_COUNT];
   tea_pkg::stage_type              request;

   assign busy = reset;

   always_comb begin
      key_zero_in  = key_zero_ff;
      key_one_in   = key_one_ff;
      key_two_in   = key_two_ff;
      key_three_in = key_three_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            tea_pkg::KEY_ZERO_INDEX:  key_zero_in  = csr_write_data;
            tea_pkg::KEY_ONE_INDEX:   key_one_in   = csr_write_data;
            tea_pkg::KEY_TWO_INDEX:   key_two_in   = csr_write_data;
            tea_pkg::KEY_THREE_INDEX: key_three_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_zero_ff  <= '0;
         key_one_ff   <= '0;
         key_two_ff   <= '0;
         key_three_ff <= '0;
      end else begin
         key_zero_ff  <= key_zero_in;
         key_one_ff   <= key_one_in;
         key_two_ff   <= key_two_in;
         key_three_ff <= key_three_in;
      end
   end

   assign request.kind   = req_kind;
   assign request.first  = req_first_half;
   assign request.second = req_second_half;

   assign valid_in = {valid_ff[tea_pkg::STAGE_COUNT-2:0], start & ~busy};

   genvar j;
   generate
      for (j = 0; j < tea_pkg::STAGE_COUNT; j++) begin : g_stage
         localparam logic ODD = 1'(j % 2);
         localparam logic [tea_pkg::WORD_WIDTH-1:0] ENC_SUM =
            tea_pkg::stage_sum(j, tea_pkg::KIND_ENCRYPT);
         localparam logic [tea_pkg::WORD_WIDTH-1:0] DEC_SUM =
            tea_pkg::stage_sum(j, tea_pkg::KIND_DECRYPT);

         tea_pkg::stage_type             cur;
         logic                           upd_first;
         logic [tea_pkg::WORD_WIDTH-1:0] src, tgt, key_a, key_b, sum, mix, new_tgt;

         if (j == 0) begin : g_head
            assign cur = request;
         end else begin : g_body
            assign cur = pipe_ff[j-1];
         end

         // Encryption updates the first half on even stages, decryption on odd ones.
         always_comb begin
            upd_first = (cur.kind == tea_pkg::KIND_ENCRYPT) ^ ODD;
            src       = upd_first ? cur.second : cur.first;
            tgt       = upd_first ? cur.first : cur.second;
            key_a     = upd_first ? key_zero_ff : key_two_ff;
            key_b     = upd_first ? key_one_ff : key_three_ff;
            sum       = (cur.kind == tea_pkg::KIND_DECRYPT) ? DEC_SUM : ENC_SUM;
            mix       = ((src << 4) + key_a) ^ (src + sum) ^ ((src >> 5) + key_b);
            new_tgt   = (cur.kind == tea_pkg::KIND_DECRYPT) ? (tgt - mix) : (tgt + mix);
            pipe_in[j].kind   = cur.kind;
            pipe_in[j].first  = upd_first ? new_tgt : cur.first;
            pipe_in[j].second = upd_first ? cur.second : new_tgt;
         end

         always_ff @(posedge clock) begin
            pipe_ff[j] <= pipe_in[j];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid         = valid_ff[LAST];
   assign rsp_result_first  = pipe_ff[LAST].first;
   assign rsp_result_second = pipe_ff[LAST].second;

   // A result only ever appears exactly one pipeline depth after an accepted item.
   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, tea_pkg::STAGE_COUNT))
      else $error("result strobe without an item accepted one pipeline depth earlier");

   // The operation kind travels with its item through every stage.
   a_kind_travels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pipe_ff[LAST].kind == $past(req_kind, tea_pkg::STAGE_COUNT)))
      else $error("operation kind at the pipeline end does not match the accepted item");

   // Nothing enters the pipeline while reset holds the block busy.
   a_no_entry_in_reset: assert property (@(posedge clock)
      reset |=> !valid_ff[0])
      else $error("item entered the pipeline during reset");

endmodule
